// ===== sv/rms_pkg.sv =====
// ----------------------------------------------------------------------------
// rms_pkg: shared definitions for the running median subtract block
// Register indexes and reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ChanOutW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_LENGTH  = 4'd0,
    REG_NUM_CHANNELS = 4'd1
  } reg_idx_e;

  localparam logic [3:0] HalfLengthReset  = 4'd10;
  localparam logic [5:0] NumChannelsReset = 6'd1;

endpackage

`default_nettype wire

// ===== sv/running_median_subtract.sv =====
// ----------------------------------------------------------------------------
// running_median_subtract: multichannel running median high-pass filter
// Each sample replaces the oldest of its channel window; the centre sample
// minus the window median is emitted once the channel has warmed up.
// ----------------------------------------------------------------------------
// An accepted sample is registered in stage A, then in the output register.
// Throughput: one sample per cycle unless the output stalls; the per-channel
//   row memory is read into a register when a sample is accepted, written
//   back in the compute cycle, bypassed when consecutive samples share a channel.
// Reset: asynchronous, clears control state and the per-row valid bits, so
//   every window reads as all zeros; a write to a known register does the same.
`default_nettype none

module running_median_subtract
  import rms_pkg::*;
#(
  parameter int unsigned MAX_HALF_LENGTH = 15,
  parameter int unsigned MAX_CHANNELS    = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // sample input
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic signed [15:0]  sample_i,
  // result output
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic signed [15:0]  filtered_value_o,
  output      logic [4:0]          channel_o,
  output      logic                overflow_o
);

  localparam int unsigned WinMax = 2 * MAX_HALF_LENGTH + 1;
  localparam int unsigned IW     = $clog2(WinMax + 1);           // holds w itself
  localparam int unsigned LW     = $clog2(MAX_HALF_LENGTH + 1);  // holds L
  localparam int unsigned ChW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NW     = $clog2(MAX_CHANNELS + 1);     // holds channel count

  typedef logic [WinMax-1:0][15:0] row_t;

  // --------------------------------------------------------------------------
  // Configuration registers. Any write to a known register restarts filtering.
  // --------------------------------------------------------------------------
  logic [3:0] half_length_q;
  logic [5:0] num_channels_q;
  logic       cfg_we;
  logic       cfg_clear;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_we && ((cfg_index_i == REG_HALF_LENGTH) ||
                                  (cfg_index_i == REG_NUM_CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_length_q  <= HalfLengthReset;
      num_channels_q <= NumChannelsReset;
    end else if (cfg_we) begin
      if (cfg_index_i == REG_HALF_LENGTH) begin
        half_length_q <= cfg_data_i[3:0];
      end
      if (cfg_index_i == REG_NUM_CHANNELS) begin
        num_channels_q <= cfg_data_i;
      end
    end
  end

  // Effective L and channel count, clamped to the supported range.
  logic [LW-1:0] half_eff;
  logic [NW-1:0] nch_eff;
  logic [IW-1:0] win_len;

  always_comb begin
    if (half_length_q == 4'd0) begin
      half_eff = LW'(1);
    end else if (32'(half_length_q) > MAX_HALF_LENGTH) begin
      half_eff = LW'(MAX_HALF_LENGTH);
    end else begin
      half_eff = LW'(half_length_q);
    end
    if (num_channels_q == 6'd0) begin
      nch_eff = NW'(1);
    end else if (32'(num_channels_q) > MAX_CHANNELS) begin
      nch_eff = NW'(MAX_CHANNELS);
    end else begin
      nch_eff = NW'(num_channels_q);
    end
    win_len = IW'({half_eff, 1'b1});
  end

  // --------------------------------------------------------------------------
  // Handshake. Stage A holds the accepted sample and its channel row; the
  // output register follows. Stage A still takes a transaction while the
  // output waits, as long as it is empty itself.
  // --------------------------------------------------------------------------
  logic           a_valid_q;
  logic [15:0]    a_sample_q;
  logic [ChW-1:0] a_chan_q;
  logic           out_valid_q;
  logic           adv;        // stage A may move into the output register
  logic           proc;       // stage A item is processed this cycle
  logic           accept;

  assign adv        = !out_valid_q || !out_stall_i;
  assign proc       = a_valid_q && adv;
  assign in_stall_o = a_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  // channel pointer
  logic [ChW-1:0] chan_pos_q;
  logic [ChW-1:0] chan_pos_nxt;

  always_comb begin
    if ((NW'(chan_pos_q) + NW'(1)) >= nch_eff) begin
      chan_pos_nxt = '0;
    end else begin
      chan_pos_nxt = chan_pos_q + ChW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Per-channel rows: delay line (newest first) and sorted window.
  // A row never written since the last clear reads as zeros.
  // --------------------------------------------------------------------------
  row_t dl_mem [MAX_CHANNELS];
  row_t sw_mem [MAX_CHANNELS];
  row_t dl_rd_q, sw_rd_q;
  logic [MAX_CHANNELS-1:0] row_ok_q;
  logic rd_ok_q;
  logic fwd;

  row_t dl_new, sw_new;

  assign fwd = proc && (a_chan_q == chan_pos_q);

  always_ff @(posedge clk_i) begin
    if (proc) begin
      dl_mem[a_chan_q] <= dl_new;
      sw_mem[a_chan_q] <= sw_new;
    end
    if (accept) begin
      dl_rd_q <= fwd ? dl_new : dl_mem[chan_pos_q];
      sw_rd_q <= fwd ? sw_new : sw_mem[chan_pos_q];
    end
  end

  logic [LW-1:0] warm_q [MAX_CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      chan_pos_q <= '0;
      row_ok_q   <= '0;
      rd_ok_q    <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        warm_q[c] <= '0;
      end
    end else if (cfg_clear) begin
      a_valid_q  <= 1'b0;
      chan_pos_q <= '0;
      row_ok_q   <= '0;
      rd_ok_q    <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        warm_q[c] <= '0;
      end
    end else begin
      if (proc) begin
        row_ok_q[a_chan_q] <= 1'b1;
        if (warm_q[a_chan_q] < half_eff) begin
          warm_q[a_chan_q] <= warm_q[a_chan_q] + LW'(1);
        end
      end
      if (accept) begin
        a_valid_q  <= 1'b1;
        chan_pos_q <= chan_pos_nxt;
        rd_ok_q    <= fwd || row_ok_q[chan_pos_q];
      end else if (proc) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sample_q <= sample_i;
      a_chan_q   <= chan_pos_q;
    end
  end

  // --------------------------------------------------------------------------
  // Window update: shift the delay line, drop the oldest sample from the
  // sorted copy (first match, or the last slot if none), insert the new one.
  // --------------------------------------------------------------------------
  row_t dl_cur, sw_cur, sw_rm;
  logic [15:0]       old_v;
  logic [WinMax-1:0] hit;
  logic [WinMax-1:0] le;
  logic              hit_acc;
  logic [15:0]       centre, median;
  logic [16:0]       diff;
  logic              warmed;

  always_comb begin
    dl_cur  = rd_ok_q ? dl_rd_q : '0;
    sw_cur  = rd_ok_q ? sw_rd_q : '0;
    old_v   = dl_cur[win_len - IW'(1)];
    hit_acc = 1'b0;
    for (int i = 0; i < WinMax; i++) begin
      dl_new[i] = (i == 0) ? a_sample_q : dl_cur[(i == 0) ? 0 : i - 1];
      hit_acc   = hit_acc || ((IW'(i) < win_len) && (sw_cur[i] == old_v));
      hit[i]    = hit_acc;
    end
    for (int i = 0; i < WinMax; i++) begin
      if ((i < WinMax - 1) && hit[i]) begin
        sw_rm[i] = sw_cur[(i < WinMax - 1) ? i + 1 : i];
      end else begin
        sw_rm[i] = sw_cur[i];
      end
      le[i] = ((IW'(i) + IW'(1)) < win_len) &&
              ($signed(sw_rm[i]) <= $signed(a_sample_q));
    end
    for (int i = 0; i < WinMax; i++) begin
      if (IW'(i) >= win_len) begin
        sw_new[i] = sw_cur[i];
      end else if (le[i]) begin
        sw_new[i] = sw_rm[i];
      end else if ((i == 0) || le[(i == 0) ? 0 : i - 1]) begin
        sw_new[i] = a_sample_q;
      end else begin
        sw_new[i] = sw_rm[(i == 0) ? 0 : i - 1];
      end
    end
    centre = dl_new[IW'(half_eff)];
    median = sw_new[IW'(half_eff)];
    diff   = {centre[15], centre} - {median[15], median};
    warmed = !(warm_q[a_chan_q] < half_eff);
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [15:0]    fv_q;
  logic [ChW-1:0] ch_q;
  logic           ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= proc && warmed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      fv_q  <= diff[15:0];
      ch_q  <= a_chan_q;
      ovf_q <= diff[16] ^ diff[15];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = fv_q;
  assign channel_o        = 5'(ch_q);
  assign overflow_o       = ovf_q;

endmodule

`default_nettype wire

// ===== sv/rms_checker.sv =====
// ----------------------------------------------------------------------------
// rms_port_checks: port-level checks for the running median subtract block
// Bound to the top level; watches the handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_port_checks (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_ready_o,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] filtered_value_o,
  input wire logic [4:0]  channel_o,
  input wire logic        overflow_o
);

  // a result that shows up from nothing came from an accepted input transaction
  a_rise_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching input transaction");

  // with the output empty the block always takes a sample
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(filtered_value_o) && $stable(channel_o) &&
       $stable(overflow_o)))
    else $error("stalled result changed");

endmodule

bind running_median_subtract rms_port_checks u_rms_port_checks (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_ready_o      (cfg_ready_o),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .filtered_value_o (filtered_value_o),
  .channel_o        (channel_o),
  .overflow_o       (overflow_o)
);

`default_nettype wire
